// ===== hw/rtl/awcb_pkg.sv =====
`default_nettype none
package awcb_pkg;

	localparam int MaxPanelWords = 64;
	localparam int StoreDepth = 64;
	localparam int IdxW = $clog2(StoreDepth);
	localparam int SizeW = 3;
	localparam int MaxSizeLog2 = $clog2(MaxPanelWords);
	localparam int InDataW = 80;
	localparam int OutDataW = 80;

	localparam logic [1:0] ModeUpdate = 2'd0;
	localparam logic [1:0] ModeBegin = 2'd1;
	localparam logic [1:0] ModeEnd = 2'd2;

	typedef struct packed {
		logic load_item;
		logic flush_start;
		logic flush_next;
		logic apply;
		logic out_err;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic is_open;
		logic pending;
		logic base_diff;
		logic flush_last;
	} sts_t;

	function automatic logic [IdxW-1:0] panel_mask(input logic [SizeW-1:0] size_log2);
		logic [IdxW:0] t;
		t = ({{IdxW{1'b0}}, 1'b1} << size_log2) - {{IdxW{1'b0}}, 1'b1};
		return t[IdxW-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/awcb_ctrl.sv =====
`default_nettype none
module awcb_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	input  awcb_pkg::sts_t     sts,
	output awcb_pkg::cmd_t     cmd
);
	import awcb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_FL_RD,
		ST_FL_OUT,
		ST_ERR
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   need_flush;

	assign need_flush = sts.is_open && sts.pending &&
		(sts.mode == ModeBegin || sts.mode == ModeEnd ||
		 (sts.mode == ModeUpdate && sts.base_diff));

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		cmd.out_err = (state_q == ST_ERR);
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					state_nxt = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.mode == ModeUpdate && !sts.is_open) begin
					state_nxt = ST_ERR;
				end else if (need_flush) begin
					cmd.flush_start = 1'b1;
					state_nxt = ST_FL_RD;
				end else begin
					cmd.apply = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			ST_FL_RD: begin
				state_nxt = ST_FL_OUT;
			end
			ST_FL_OUT: begin
				if (m_tready) begin
					if (sts.flush_last) begin
						cmd.apply = 1'b1;
						state_nxt = ST_IDLE;
					end else begin
						cmd.flush_next = 1'b1;
						state_nxt = ST_FL_RD;
					end
				end
			end
			ST_ERR: begin
				if (m_tready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_FL_OUT) || (state_q == ST_ERR);

endmodule
`default_nettype wire

// ===== hw/rtl/awcb_datapath.sv =====
`default_nettype none
module awcb_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [1:0]                     s_tuser,
	input  wire logic [awcb_pkg::InDataW-1:0]   s_tdata,
	output logic [awcb_pkg::OutDataW-1:0]       m_tdata,
	output logic                                m_tuser,
	output logic                                m_tlast,
	input  awcb_pkg::cmd_t                      cmd,
	output awcb_pkg::sts_t                      sts
);
	import awcb_pkg::*;

	logic [1:0]       mode_q;
	logic [31:0]      addr_q;
	logic [31:0]      data_q;
	logic [7:0]       item_region_q;
	logic [SizeW-1:0] item_size_q;

	logic             open_q;
	logic             pending_q;
	logic [7:0]       region_q;
	logic [SizeW-1:0] size_q;
	logic [31:0]      base_q;

	logic [31:0]           mem [StoreDepth];
	logic [StoreDepth-1:0] valid_q;
	logic [IdxW-1:0]       idx_q;
	logic [31:0]           rd_q;
	logic                  rd_valid_q;

	logic [IdxW-1:0]  mask;
	logic [31:0]      new_base;
	logic [IdxW-1:0]  offset;
	logic [SizeW-1:0] size_clamped;
	logic [31:0]      word_value;

	assign mask = panel_mask(size_q);
	assign new_base = addr_q & ~{{(32-IdxW){1'b0}}, mask};
	assign offset = addr_q[IdxW-1:0] & mask;
	assign size_clamped = (item_size_q > SizeW'(MaxSizeLog2)) ?
		SizeW'(MaxSizeLog2) : item_size_q;
	assign word_value = rd_valid_q ? rd_q : 32'hFFFF_FFFF;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q <= s_tuser;
			addr_q <= s_tdata[31:0];
			data_q <= s_tdata[63:32];
			item_region_q <= s_tdata[71:64];
			item_size_q <= s_tdata[74:72];
		end
		rd_q <= mem[idx_q];
		if (cmd.apply && mode_q == ModeUpdate) begin
			mem[offset] <= data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			pending_q <= 1'b0;
			region_q <= '0;
			size_q <= '0;
			base_q <= '0;
			valid_q <= '0;
			idx_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[idx_q];
			if (cmd.flush_start) begin
				idx_q <= '0;
			end else if (cmd.flush_next) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.apply) begin
				case (mode_q)
					ModeBegin: begin
						region_q <= item_region_q;
						size_q <= size_clamped;
						base_q <= '0;
						valid_q <= '0;
						open_q <= 1'b1;
						pending_q <= 1'b0;
					end
					ModeEnd: begin
						if (open_q) begin
							open_q <= 1'b0;
							pending_q <= 1'b0;
							region_q <= '0;
							size_q <= '0;
							base_q <= '0;
						end
					end
					ModeUpdate: begin
						if (new_base != base_q) begin
							base_q <= new_base;
						end
						valid_q <= (((new_base != base_q) && pending_q) ? '0 : valid_q) |
							({{(StoreDepth-1){1'b0}}, 1'b1} << offset);
						pending_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		sts.mode = mode_q;
		sts.is_open = open_q;
		sts.pending = pending_q;
		sts.base_diff = (new_base != base_q);
		sts.flush_last = (idx_q == mask);
	end

	always_comb begin
		if (cmd.out_err) begin
			m_tdata = '0;
			m_tuser = 1'b1;
			m_tlast = 1'b1;
		end else begin
			m_tdata = {2'b00, word_value, idx_q, base_q, region_q};
			m_tuser = 1'b0;
			m_tlast = (idx_q == mask);
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/aligned_write_combining_buffer.sv =====
// An item is taken in ST_IDLE and decided in the next cycle, in ST_DECIDE; an item that causes
// no flush frees the input on the return to ST_IDLE, and an error beat appears in ST_ERR.
// A flush streams the panel one word at a time: a registered store read (ST_FL_RD), then
// an output beat (ST_FL_OUT) held through any output stall; the next read waits for that beat.
// Reset clears the controller, the panel state and the store's valid bits, so every store
// entry reads as all ones right after reset; there is no clearing pass.
`default_nettype none
module aligned_write_combining_buffer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// address[31:0], data_word[63:32], region[71:64], size_log2[74:72], zero pad.
	input  wire logic [awcb_pkg::InDataW-1:0]  s_tdata,
	// mode[1:0].
	input  wire logic [1:0]                    s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// out_region[7:0], panel_base[39:8], word_index[45:40], word_value[77:46], zero pad.
	output logic [awcb_pkg::OutDataW-1:0]      m_tdata,
	// status[0].
	output logic                               m_tuser,
	output logic                               m_tlast
);
	import awcb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	awcb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	awcb_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.cmd     (cmd),
		.sts     (sts)
	);

`ifndef ASSERT_OFF
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while an output beat is pending");

	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
		else $error("error beat must be a single zero beat");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && !m_tvalid)
		else $error("item not held for decision after its beat");
`endif

endmodule
`default_nettype wire
